FILE: hw/rtl/mexp_pkg.sv
// Package for the modular exponentiation block: widths, reset value and controller states.
`timescale 1ns / 1ps
`default_nettype none
package mexp_pkg;

	localparam int MOD_W     = 31;
	localparam int BASE_W    = 32;
	localparam int EXP_W     = 63;
	localparam int MUL_CNT_W = $clog2(MOD_W);
	localparam int RED_CNT_W = $clog2(BASE_W);

	localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_ACC_GO,
		ST_ACC_WAIT,
		ST_SQR_GO,
		ST_SQR_WAIT,
		ST_OUT
	} mexp_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: controller, modulus register, output register.
// The base is first reduced by the modulus; then each exponent bit takes at most one multiply,
// and each bit below the highest set one a squaring, all on the modular multiplier.
// A zero exponent or zero modulus skips both and goes from acceptance straight to the output
// state. One word is in flight at a time; the shared bit-serial multiplier, at one
// modulus bit per cycle, sets the rate.
// Asynchronous active-low reset returns to idle, empties the output and loads modulus 1000000007.
`timescale 1ns / 1ps
`default_nettype none
module modular_exponentiation_top
	import mexp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BASE_W-1:0] base_value,
	input  wire logic [EXP_W-1:0]  exponent,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [MOD_W-1:0]       power_result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [MOD_W-1:0]  cfg_data
);

	mexp_state_t      state_q;
	mexp_state_t      state_next;
	logic [MOD_W-1:0] modulus_q;
	logic [MOD_W-1:0] acc_q;
	logic [MOD_W-1:0] base_q;
	logic [EXP_W-1:0] exp_q;
	logic             out_valid_q;
	logic [MOD_W-1:0] out_data_q;
	logic             in_accept;
	logic             out_free;
	logic             red_start;
	logic             red_done;
	logic [MOD_W-1:0] red_rem;
	logic             mul_start;
	logic             mul_done;
	logic [MOD_W-1:0] mul_a;
	logic [MOD_W-1:0] mul_prod;
	logic             exp_last;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign exp_last  = (exp_q[EXP_W-1:1] == '0);

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (exponent == '0 || modulus_q == '0) state_next = ST_OUT;
					else state_next = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (red_done) state_next = exp_q[0] ? ST_ACC_GO : ST_SQR_GO;
			end
			ST_ACC_GO:   state_next = ST_ACC_WAIT;
			ST_ACC_WAIT: begin
				if (mul_done) state_next = exp_last ? ST_OUT : ST_SQR_GO;
			end
			ST_SQR_GO:   state_next = ST_SQR_WAIT;
			ST_SQR_WAIT: begin
				if (mul_done) state_next = exp_q[1] ? ST_ACC_GO : ST_SQR_GO;
			end
			ST_OUT: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		red_start = 1'b0;
		mul_start = 1'b0;
		mul_a     = base_q;
		unique case (state_q)
			ST_IDLE:     red_start = in_valid && (exponent != '0) && (modulus_q != '0);
			ST_ACC_GO: begin
				mul_start = 1'b1;
				mul_a     = acc_q;
			end
			ST_SQR_GO:   mul_start = 1'b1;
			ST_REDUCE, ST_ACC_WAIT, ST_SQR_WAIT, ST_OUT: begin
				red_start = 1'b0;
			end
			default: begin
				red_start = 1'b0;
			end
		endcase
	end

	// State, modulus register and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modulus_q   <= MOD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_valid && cfg_ready) modulus_q <= cfg_data;
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Working registers: accumulator, running square, remaining exponent, output data
	always_ff @(posedge clk) begin
		if (in_accept) begin
			exp_q <= exponent;
			if (exponent == '0) acc_q <= MOD_W'(1);
			else if (modulus_q == MOD_W'(1) || modulus_q == '0) acc_q <= '0;
			else acc_q <= MOD_W'(1);
		end
		if (state_q == ST_REDUCE && red_done) base_q <= red_rem;
		if (state_q == ST_ACC_WAIT && mul_done) acc_q <= mul_prod;
		if (state_q == ST_SQR_WAIT && mul_done) begin
			base_q <= mul_prod;
			exp_q  <= {1'b0, exp_q[EXP_W-1:1]};
		end
		if (state_q == ST_OUT && out_free) out_data_q <= acc_q;
	end

	mexp_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (red_start),
		.base_in   (base_value),
		.modulus   (modulus_q),
		.done      (red_done),
		.remainder (red_rem)
	);

	mexp_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (mul_a),
		.op_b    (base_q),
		.modulus (modulus_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign power_result = out_data_q;

endmodule
`default_nettype wire

FILE: hw/rtl/mexp_reduce.sv
// Bit-serial reduction of the base by the modulus, one base bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mexp_reduce
	import mexp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [BASE_W-1:0] base_in,
	input  wire logic [MOD_W-1:0]  modulus,
	output logic                   done,
	output logic [MOD_W-1:0]       remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [RED_CNT_W-1:0] cnt_q;
	logic [BASE_W-1:0]    base_sh_q;
	logic [MOD_W-1:0]     rem_q;
	logic [MOD_W:0]       shifted;
	logic [MOD_W:0]       diff;
	logic [MOD_W-1:0]     rem_next;

	// Shift in the next base bit and subtract the modulus when it fits
	always_comb begin
		shifted  = {rem_q, base_sh_q[BASE_W-1]};
		diff     = shifted - {1'b0, modulus};
		rem_next = (shifted >= {1'b0, modulus}) ? diff[MOD_W-1:0] : shifted[MOD_W-1:0];
	end

	// Control: count base bits, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == RED_CNT_W'(BASE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load the base, then advance one bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			base_sh_q <= base_in;
			rem_q     <= '0;
		end else if (busy_q) begin
			base_sh_q <= {base_sh_q[BASE_W-2:0], 1'b0};
			rem_q     <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

FILE: hw/rtl/mexp_modmul.sv
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mexp_modmul
	import mexp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [MOD_W-1:0] op_a,
	input  wire logic [MOD_W-1:0] op_b,
	input  wire logic [MOD_W-1:0] modulus,
	output logic                  done,
	output logic [MOD_W-1:0]      product
);

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [MOD_W-1:0]     a_sh_q;
	logic [MOD_W-1:0]     b_q;
	logic [MOD_W-1:0]     acc_q;
	logic [MOD_W:0]       m_ext;
	logic [MOD_W:0]       dbl;
	logic [MOD_W:0]       dbl_sub;
	logic [MOD_W-1:0]     dbl_red;
	logic [MOD_W:0]       sum;
	logic [MOD_W:0]       sum_sub;
	logic [MOD_W-1:0]     acc_next;

	// Double the partial result, reduce, add b when the multiplier bit is set, reduce
	always_comb begin
		m_ext    = {1'b0, modulus};
		dbl      = {acc_q, 1'b0};
		dbl_sub  = dbl - m_ext;
		dbl_red  = (dbl >= m_ext) ? dbl_sub[MOD_W-1:0] : dbl[MOD_W-1:0];
		sum      = {1'b0, dbl_red} + (a_sh_q[MOD_W-1] ? {1'b0, b_q} : '0);
		sum_sub  = sum - m_ext;
		acc_next = (sum >= m_ext) ? sum_sub[MOD_W-1:0] : sum[MOD_W-1:0];
	end

	// Control: count multiplier bits, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MOD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: latch operands, then advance MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			a_sh_q <= op_a;
			b_q    <= op_b;
			acc_q  <= '0;
		end else if (busy_q) begin
			a_sh_q <= {a_sh_q[MOD_W-2:0], 1'b0};
			acc_q  <= acc_next;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

FILE: test/modular_exponentiation_top_tb.sv
// Self-checking bench for the modular exponentiation block under randomized flow control.
`timescale 1ns / 1ps
module modular_exponentiation_top_tb
	import mexp_pkg::*;
;

	localparam int          IDLE_LIMIT   = 40000;
	localparam int          SETTLE_TICKS = 12;
	localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};
	localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};

	// Track the configured modulus and the powers still owed by the block.
	class power_ledger;
		logic [MOD_W-1:0] modulus;
		logic [MOD_W-1:0] pending_powers[$];
		int unsigned      mismatches;
		int unsigned      results_seen;

		function new();
			modulus      = MOD_RESET;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		// Square-and-multiply from the low exponent bit upward, 64-bit products.
		function logic [MOD_W-1:0] power_mod(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e,
				logic [MOD_W-1:0] m);
			bit [63:0]        acc;
			bit [63:0]        sq;
			bit [63:0]        mm;
			bit [EXP_W-1:0]   rest;
			mm   = 64'(m);
			rest = e;
			if (e == '0) begin
				acc = 64'd1;
			end else if (m == '0) begin
				acc = 64'd0;
			end else begin
				acc = 64'd1 % mm;
				sq  = 64'(b) % mm;
				while (rest != '0) begin
					if (rest[0])
						acc = (acc * sq) % mm;
					sq   = (sq * sq) % mm;
					rest = rest >> 1;
				end
			end
			return acc[MOD_W-1:0];
		endfunction

		function void note_operands(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e);
			pending_powers.push_back(power_mod(b, e, modulus));
		endfunction

		function void check_power(logic [MOD_W-1:0] got);
			logic [MOD_W-1:0] want;
			results_seen++;
			if (pending_powers.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected power_result word, expected none, actual %0d",
					$time, got);
			end else begin
				want = pending_powers.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: power_result mismatch, expected %0d, actual %0d",
						$time, want, got);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [BASE_W-1:0]   base_value = '0;
	logic [EXP_W-1:0]    exponent   = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [MOD_W-1:0]    power_result;
	logic                cfg_valid  = 1'b0;
	logic                cfg_ready;
	logic [MOD_W-1:0]    cfg_data   = '0;

	power_ledger         ledger;
	int unsigned         burst_left = 1;
	int unsigned         words_sent = 0;
	int unsigned         moduli_set = 0;
	int unsigned         idle_cycles = 0;
	int unsigned         tick = 0;

	modular_exponentiation_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.base_value   (base_value),
		.exponent     (exponent),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.power_result (power_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check each accepted result word; stall on a pattern that rotates through modes.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			ledger.check_power(power_result);
		tick <= tick + 1;
		case (tick[9:8])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 3) == 0);
			2'd2: out_stall <= (tick[2:0] < 3'd3);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	// Abort when no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one operand word; hold it until accepted, then maybe end the burst.
	task automatic send_word(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e);
		int unsigned gap;
		in_valid   <= 1'b1;
		base_value <= b;
		exponent   <= e;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		ledger.note_operands(b, e);
		words_sent++;
		burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 6);
			gap        = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mostly short exponents keep the run fast; a few span the full width.
	task automatic send_random(int unsigned count);
		logic [BASE_W-1:0] b;
		logic [EXP_W-1:0]  e;
		int unsigned       w;
		repeat (count) begin
			b = ($urandom_range(0, 4) == 0) ? BASE_W'($urandom_range(0, 15)) : $urandom;
			case ($urandom_range(0, 9))
				0: e = EXP_W'({$urandom, $urandom});
				1: e = EXP_W'($urandom_range(0, 1));
				default: begin
					w = $urandom_range(1, 12);
					e = EXP_W'($urandom & ((32'd1 << w) - 1));
				end
			endcase
			send_word(b, e);
		end
	endtask

	// Drop valid and wait until every owed result has been checked.
	task automatic drain();
		in_valid <= 1'b0;
		while (ledger.pending_powers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_modulus(logic [MOD_W-1:0] m);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		cfg_valid <= 1'b0;
		ledger.modulus = m;
		moduli_set++;
		@(posedge clk);
	endtask

	initial begin
		ledger = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset modulus: operand extremes, base at and above the modulus, Fermat case.
		send_word('0, '0);
		send_word('0, EXP_W'(1));
		send_word({BASE_W{1'b1}}, EXP_W'(1));
		send_word({BASE_W{1'b1}}, EXP_MAX);
		send_word(BASE_W'(1000000007), EXP_W'(3));
		send_word(BASE_W'(1000000008), EXP_W'(5));
		send_word(BASE_W'(2), EXP_W'(1000000006));
		send_word(BASE_W'(12345), EXP_MAX);
		send_word(BASE_W'(3), EXP_W'(1) << (EXP_W - 1));
		send_word(BASE_W'(7), '0);
		send_random(20);
		drain();

		// Largest modulus.
		write_modulus(MOD_MAX);
		send_word({BASE_W{1'b1}}, EXP_MAX);
		send_word(BASE_W'(MOD_MAX), EXP_W'(7));
		send_random(25);
		drain();

		// Modulus of one: zero exponent still gives one, anything else zero.
		write_modulus(MOD_W'(1));
		send_word({BASE_W{1'b1}}, '0);
		send_word(BASE_W'(5), EXP_W'(1));
		send_word(BASE_W'(9), EXP_MAX);
		send_random(10);
		drain();

		// Modulus of zero: no reduction, same outcome as modulus one.
		write_modulus('0);
		send_word(BASE_W'(4), '0);
		send_word(BASE_W'(4), EXP_W'(1));
		send_word({BASE_W{1'b1}}, EXP_MAX);
		send_random(10);
		drain();

		write_modulus(MOD_W'(2));
		send_random(15);
		drain();

		write_modulus(MOD_W'($urandom_range(2, 32'h7FFF_FFFF)));
		send_random(21);
		drain();

		write_modulus(MOD_W'($urandom_range(3, 1000)));
		send_random(21);
		drain();

		$display("Covered %0d operand words across %0d modulus writes plus the reset value,",
			words_sent, moduli_set);
		$display("including zero and one moduli and full-width exponents; %0d results checked.",
			ledger.results_seen);
		if (ledger.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_reduce.sv
hw/rtl/mexp_modmul.sv
hw/rtl/modular_exponentiation_top.sv
test/modular_exponentiation_top_tb.sv
